>>> design/amic_pkg.sv
// Shared types, constants and the CRC byte function for the archive member checker.
`default_nettype none

package amic_pkg;

  // Field widths
  localparam int SIZE_BITS      = 48;
  localparam int CRC_BITS       = 32;
  localparam int STATUS_BITS    = 3;
  localparam int COUNT_BITS_DEF = 48;

  // Configuration port geometry (64-bit registers at byte addresses 8*i)
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_IDX_BIT   = 3;

  // Register indexes
  localparam logic REG_EXPECTED_SIZE = 1'b0;
  localparam logic REG_EXPECTED_CRC  = 1'b1;

  // CRC-32, reflected form
  localparam logic [CRC_BITS-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_BITS-1:0] CRC_ONES = 32'hFFFF_FFFF;

  // Verdict codes
  localparam logic [STATUS_BITS-1:0] STATUS_RUNNING  = 3'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_OK       = 3'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_OVERSIZE = 3'd2;
  localparam logic [STATUS_BITS-1:0] STATUS_SHORT    = 3'd3;
  localparam logic [STATUS_BITS-1:0] STATUS_CRC_BAD  = 3'd4;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       end_of_member;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [CRC_BITS-1:0]    crc_value;
    logic [SIZE_BITS-1:0]   bytes_seen;
  } out_item_t;

  // Configuration values seen by the checker core
  typedef struct packed {
    logic [SIZE_BITS-1:0] size_limit;
    logic [CRC_BITS-1:0]  expected_crc;
  } cfg_t;

  // One byte through the reflected CRC, bit at a time
  function automatic logic [CRC_BITS-1:0] crc_byte(input logic [CRC_BITS-1:0] crc,
                                                   input logic [7:0] data);
    logic [CRC_BITS-1:0] v;
    v = {24'b0, crc[7:0] ^ data};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v ^ (crc >> 8);
  endfunction

endpackage

`default_nettype wire

>>> design/amic_cfg.sv
// APB-style register file holding the declared size and declared CRC.
`default_nettype none

module amic_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [amic_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  wire logic [amic_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic      [amic_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                     pready,
  output amic_pkg::cfg_t                           cfg
);

  logic [amic_pkg::SIZE_BITS-1:0] size_r;
  logic [amic_pkg::CRC_BITS-1:0]  crc_r;
  logic                           wr_en;
  logic                           idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[amic_pkg::CFG_IDX_BIT];

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
      crc_r  <= '0;
    end else if (wr_en) begin
      unique case (idx)
        amic_pkg::REG_EXPECTED_SIZE: size_r <= pwdata[amic_pkg::SIZE_BITS-1:0];
        amic_pkg::REG_EXPECTED_CRC:  crc_r  <= pwdata[amic_pkg::CRC_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      amic_pkg::REG_EXPECTED_SIZE:
        prdata = amic_pkg::CFG_DATA_BITS'(size_r);
      amic_pkg::REG_EXPECTED_CRC:
        prdata = amic_pkg::CFG_DATA_BITS'(crc_r);
      default:
        prdata = '0;
    endcase
  end

  assign cfg.size_limit   = size_r;
  assign cfg.expected_crc = crc_r;

endmodule

`default_nettype wire

>>> design/amic_core.sv
// Member state (CRC, byte count, overflow flag) and the per-item verdict logic.
`default_nettype none

module amic_core #(
  parameter int COUNT_BITS = amic_pkg::COUNT_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                advance,
  input  wire amic_pkg::in_item_t  item,
  input  wire amic_pkg::cfg_t      cfg,
  output amic_pkg::out_item_t      result
);

  // Common width for count vs. declared size compares
  localparam int CMP_BITS = (COUNT_BITS > amic_pkg::SIZE_BITS) ? COUNT_BITS
                                                               : amic_pkg::SIZE_BITS;

  logic [amic_pkg::CRC_BITS-1:0] crc_r, crc_nxt, crc_upd, final_crc;
  logic [COUNT_BITS-1:0]         count_r, count_nxt, count_upd;
  logic                          ovf_r, ovf_nxt, ovf_upd;
  logic [CMP_BITS-1:0]           count_ext, count_upd_ext, size_ext;
  logic                          room, take;

  // Byte acceptance: below declared size and count not saturated
  assign count_ext = CMP_BITS'(count_r);
  assign size_ext  = CMP_BITS'(cfg.size_limit);
  assign room      = (count_ext < size_ext) && !(&count_r);
  assign take      = item.has_byte && room;

  assign crc_upd       = take ? amic_pkg::crc_byte(crc_r, item.data_byte) : crc_r;
  assign count_upd     = take ? count_r + COUNT_BITS'(1) : count_r;
  assign ovf_upd       = ovf_r || (item.has_byte && !room);
  assign count_upd_ext = CMP_BITS'(count_upd);
  assign final_crc     = crc_upd ^ amic_pkg::CRC_ONES;

  // Verdict and result fields
  always_comb begin
    result.bytes_seen = count_upd_ext[amic_pkg::SIZE_BITS-1:0];
    if (item.end_of_member) begin
      result.crc_value = final_crc;
      if (ovf_upd) begin
        result.status = amic_pkg::STATUS_OVERSIZE;
      end else if (count_upd_ext != size_ext) begin
        result.status = amic_pkg::STATUS_SHORT;
      end else if (final_crc != cfg.expected_crc) begin
        result.status = amic_pkg::STATUS_CRC_BAD;
      end else begin
        result.status = amic_pkg::STATUS_OK;
      end
    end else begin
      result.crc_value = crc_upd;
      result.status    = amic_pkg::STATUS_RUNNING;
    end
  end

  // Next state: clear after any verdict
  always_comb begin
    if (item.end_of_member) begin
      crc_nxt   = amic_pkg::CRC_ONES;
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else begin
      crc_nxt   = crc_upd;
      count_nxt = count_upd;
      ovf_nxt   = ovf_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= amic_pkg::CRC_ONES;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (advance) begin
      crc_r   <= crc_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

`ifndef SYNTHESIS
  // A verdict leaves the member state cleared
  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.end_of_member |=>
      crc_r == amic_pkg::CRC_ONES && count_r == '0 && !ovf_r)
    else $error("member state not cleared after verdict");

  // State only moves when an item is processed
  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(crc_r) && $stable(count_r) && $stable(ovf_r))
    else $error("member state changed without an item");

  // A sticky overflow always wins the verdict
  a_overflow_wins: assert property (@(posedge clk) disable iff (!rst_n)
    advance && ovf_r && item.end_of_member |->
      result.status == amic_pkg::STATUS_OVERSIZE)
    else $error("overflow not reported at end of member");
`endif

endmodule

`default_nettype wire

>>> design/archive_member_integrity_checker_top.sv
// Top level: input register, checker core, output register and config port.
// Pipeline: an item accepted into the input register has its result captured in the
//   output register when advance is high (output register empty or out_ready high).
// Throughput: one byte per cycle while the output is not stalled; the CRC byte update
//   and count compare form a loop on the member state registers.
// Reset: synchronous active-low rst_n clears both pipeline valids, presets the CRC
//   to all ones, zeroes the byte count, overflow flag and both config registers.
`default_nettype none

module archive_member_integrity_checker_top #(
  parameter int COUNT_BITS = amic_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire amic_pkg::in_item_t                  in_data,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output amic_pkg::out_item_t                      out_data,
  // configuration port
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [amic_pkg::CFG_ADDR_BITS-1:0]  cfg_paddr,
  input  wire logic [amic_pkg::CFG_DATA_BITS-1:0]  cfg_pwdata,
  output logic      [amic_pkg::CFG_DATA_BITS-1:0]  cfg_prdata,
  output logic                                     cfg_pready
);

  amic_pkg::cfg_t      cfg;
  amic_pkg::in_item_t  in_item_r;
  amic_pkg::out_item_t out_data_r, result;
  logic                in_valid_r, out_valid_r;
  logic                advance;

  amic_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Item moves from the input register to the output register
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
  end

  amic_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_item_r),
    .cfg     (cfg),
    .result  (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
